/* src/lcmp_pkg.sv */
package lcmp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 18;
   localparam int unsigned KIND_W   = 16;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned FEAT_W   = 64;
   localparam int unsigned CHAN_W   = 64;
   localparam int unsigned CHAN_N   = 4;
   localparam int unsigned STATUS_W = 3;

   localparam int unsigned RSP_BITS = STATUS_W + 2 * FEAT_W + 3 * LEN_W + CHAN_N * CHAN_W;
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [KIND_W-1:0] TYPE_INIT    = 16'd16;
   localparam logic [KIND_W-1:0] TYPE_ERROR   = 16'd17;
   localparam logic [KIND_W-1:0] TYPE_PING    = 16'd18;
   localparam logic [KIND_W-1:0] TYPE_WARNING = 16'd1;

   localparam logic [STATUS_W-1:0] ST_INIT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PING    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_WARNING = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd5;

   localparam logic [COUNT_W-1:0] HDR_LEN      = 18'd2;
   localparam logic [COUNT_W-1:0] LEN1_END     = 18'd4;
   localparam logic [COUNT_W-1:0] PING_LEN     = 18'd6;
   localparam logic [COUNT_W-1:0] FOLD_LIMIT   = 18'd8;
   localparam logic [COUNT_W-1:0] CHAN_END     = 18'd34;
   localparam logic [COUNT_W-1:0] ERR_HDR_LEN  = 18'd36;

   function automatic logic [LEN_W-1:0] put_half(input logic [LEN_W-1:0] word,
                                                 input logic high,
                                                 input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] r;
      if (high) begin
         r = {b, word[7:0]};
      end else begin
         r = {word[15:8], b};
      end
      return r;
   endfunction

endpackage

/* src/lightning_control_message_parser.sv */
// Control message parser for a peer link.
// The req_ channel carries one message byte per beat in wire order; req_tlast
// marks the final byte of a message. The first two bytes are a big-endian type.
// Init, ping, error and warning bodies are decoded into the result fields.
// One result beat leaves on rsp_ for every beat that carries req_tlast; other
// beats give no result. The result's status tells init, ping, error, warning,
// unknown type or too short, and fields that do not belong to it are zero.
// The result is registered at the edge that takes the last byte and is shown
// on the following cycle.
// The parser takes one byte per cycle while req_tready is high; each byte
// updates the parse state in the same cycle it is taken.
// req_tready is high while the result register is empty or being drained, so
// a stalled receiver holds the result and stops the input, for every byte,
// until that result beat is taken.
// Reset clears the parse state and empties the result register; the next byte
// is taken as the first byte of a new message.
module lightning_control_message_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0 up: msg_byte.
   input  logic [lcmp_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0 up: status, global_feats, local_feats, pong_bytes, pad_len,
   // text_len, chan_word0, chan_word1, chan_word2, chan_word3, zero fill.
   output logic [lcmp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import lcmp_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [LEN_W-1:0]   len1_ff, len1_in;
   logic [LEN_W-1:0]   len2_ff, len2_in;
   logic [FEAT_W-1:0]  gacc_ff, gacc_in;
   logic [FEAT_W-1:0]  lacc_ff, lacc_in;
   logic [CHAN_W-1:0]  chan_ff [CHAN_N];
   logic [CHAN_W-1:0]  chan_in [CHAN_N];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic [BYTE_W-1:0]  b;
   logic [COUNT_W-1:0] p, g, s, end1, end2, end3, pm2, g_new, s_new;
   logic [1:0]         w;
   logic [STATUS_W-1:0] status;
   logic [FEAT_W-1:0]  out_g, out_l;
   logic [LEN_W-1:0]   out_pong, out_pad, out_text;
   logic [CHAN_W-1:0]  out_chan [CHAN_N];
   logic               is_err;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign b = req_tdata;
   assign p = count_ff;
   assign g = COUNT_W'(len1_ff);
   assign s = COUNT_W'(len2_ff);
   assign end1 = LEN1_END + g;
   assign end2 = PING_LEN + g;
   assign end3 = end2 + s;
   assign pm2 = p - HDR_LEN;
   assign w = pm2[4:3];
   assign count_in = (p == COUNT_MAX) ? COUNT_MAX : p + 1'b1;

   always_comb begin
      kind_in = kind_ff;
      len1_in = len1_ff;
      len2_in = len2_ff;
      gacc_in = gacc_ff;
      lacc_in = lacc_ff;
      for (int i = 0; i < CHAN_N; i++) begin
         chan_in[i] = chan_ff[i];
      end
      if (p < HDR_LEN) begin
         kind_in = put_half(kind_ff, p == '0, b);
      end else if (kind_ff == TYPE_INIT) begin
         if (p < LEN1_END) begin
            len1_in = put_half(len1_ff, p == HDR_LEN, b);
         end else if (p < end1) begin
            if (p < LEN1_END + FOLD_LIMIT) begin
               gacc_in = {gacc_ff[FEAT_W-BYTE_W-1:0], b};
            end
         end else if (p < end2) begin
            len2_in = put_half(len2_ff, p == end1, b);
         end else if (p < end3) begin
            if (p < end2 + FOLD_LIMIT) begin
               lacc_in = {lacc_ff[FEAT_W-BYTE_W-1:0], b};
            end
         end
      end else if (kind_ff == TYPE_PING) begin
         if (p < LEN1_END) begin
            len1_in = put_half(len1_ff, p == HDR_LEN, b);
         end else if (p < PING_LEN) begin
            len2_in = put_half(len2_ff, p == LEN1_END, b);
         end
      end else if (kind_ff == TYPE_ERROR || kind_ff == TYPE_WARNING) begin
         if (p < CHAN_END) begin
            chan_in[w] = {chan_ff[w][CHAN_W-BYTE_W-1:0], b};
         end else if (p < ERR_HDR_LEN) begin
            len1_in = put_half(len1_ff, p == CHAN_END, b);
         end
      end
   end

   assign g_new = COUNT_W'(len1_in);
   assign s_new = COUNT_W'(len2_in);
   assign is_err = (kind_in == TYPE_ERROR) || (kind_in == TYPE_WARNING);

   always_comb begin
      status = ST_UNKNOWN;
      out_g = '0;
      out_l = '0;
      out_pong = '0;
      out_pad = '0;
      out_text = '0;
      for (int i = 0; i < CHAN_N; i++) begin
         out_chan[i] = '0;
      end
      if (count_in < HDR_LEN) begin
         status = ST_SHORT;
      end else if (kind_in == TYPE_INIT) begin
         if (count_in < PING_LEN || count_in < PING_LEN + g_new ||
             count_in < PING_LEN + g_new + s_new) begin
            status = ST_SHORT;
         end else begin
            status = ST_INIT;
            out_g = gacc_in;
            out_l = lacc_in;
         end
      end else if (kind_in == TYPE_PING) begin
         if (count_in < PING_LEN) begin
            status = ST_SHORT;
         end else begin
            status = ST_PING;
            out_pong = len1_in;
            out_pad = len2_in;
         end
      end else if (is_err) begin
         if (count_in < ERR_HDR_LEN || count_in < ERR_HDR_LEN + g_new) begin
            status = ST_SHORT;
         end else begin
            status = (kind_in == TYPE_ERROR) ? ST_ERROR : ST_WARNING;
            out_text = len1_in;
            for (int i = 0; i < CHAN_N; i++) begin
               out_chan[i] = chan_in[i];
            end
         end
      end
   end

   assign rsp_data_in = RSP_DATA_W'({out_chan[3], out_chan[2], out_chan[1], out_chan[0],
                                     out_text, out_pad, out_pong, out_l, out_g, status});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         rsp_valid_in = req_accept && req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         kind_ff <= '0;
         len1_ff <= '0;
         len2_ff <= '0;
         gacc_ff <= '0;
         lacc_ff <= '0;
         for (int i = 0; i < CHAN_N; i++) begin
            chan_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            if (req_tlast) begin
               count_ff <= '0;
               kind_ff <= '0;
               len1_ff <= '0;
               len2_ff <= '0;
               gacc_ff <= '0;
               lacc_ff <= '0;
               for (int i = 0; i < CHAN_N; i++) begin
                  chan_ff[i] <= '0;
               end
            end else begin
               count_ff <= count_in;
               kind_ff <= kind_in;
               len1_ff <= len1_in;
               len2_ff <= len2_in;
               gacc_ff <= gacc_in;
               lacc_ff <= lacc_in;
               for (int i = 0; i < CHAN_N; i++) begin
                  chan_ff[i] <= chan_in[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> rsp_tvalid)
      else $error("Last byte did not produce a result.");

   a_last_clears_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> count_ff == '0)
      else $error("Byte count not cleared after the last byte.");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_tlast && count_ff != COUNT_MAX |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Byte count did not advance by one.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[STATUS_W-1:0] <= ST_SHORT)
      else $error("Result status out of range.");

endmodule
